[rtl/core/tfn_pkg.sv]
package tfn_pkg;

  // Field widths
  localparam int COORD_W = 32;   // Q16.16 vertex coordinate
  localparam int EDGE_W  = 33;   // Q17.16 exact edge difference
  localparam int UNIT_W  = 32;   // Q2.30 unit component
  localparam int CROSS_W = 63;   // Q3.60 cross product of unit edges
  localparam int PROD_W  = 64;   // unit x unit product and sums
  localparam int MAG_W   = 31;   // normalized magnitude, top bit at 2^30
  localparam int FRAC_W  = 30;   // fraction bits of a unit component
  localparam int ROOT_W  = 32;   // integer square root of the sum of squares
  localparam int RAD_W   = 64;   // sum of three squared magnitudes
  localparam int NUM_W   = 62;   // dividend mag*2^30 + root/2
  localparam int QUO_W   = 31;   // quotient magnitude, at most 2^30

  typedef enum logic [1:0] {
    CORNER_A = 2'd0,
    CORNER_B = 2'd1,
    CORNER_C = 2'd2
  } corner_t;

  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef unit_t [2:0] uvec_t;

  // travels with a cross product through the final normalizer
  typedef struct packed {
    corner_t corner;
    logic    edge_deg;
  } cross_side_t;

endpackage

[rtl/core/tfn_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module tfn_isqrt #(
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [tfn_pkg::RAD_W-1:0]     rad_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          vld_o,
  output logic [tfn_pkg::ROOT_W-1:0]    root_o,
  output logic [SW-1:0]                 side_o
);

  localparam int STEPS = tfn_pkg::ROOT_W;
  localparam int RW    = tfn_pkg::RAD_W;

  logic [RW-1:0] rem_r   [STEPS];
  logic [RW-1:0] res_r   [STEPS];
  logic [SW-1:0] side_r  [STEPS];
  logic          vld_r   [STEPS];
  logic [RW-1:0] rem_nxt [STEPS];
  logic [RW-1:0] res_nxt [STEPS];
  logic [RW-1:0] rem_in  [STEPS];
  logic [RW-1:0] res_in  [STEPS];

  // stage inputs: first stage from the ports, others from the previous stage
  always_comb begin
    rem_in[0] = rad_i;
    res_in[0] = '0;
    for (int s = 1; s < STEPS; s++) begin
      rem_in[s] = rem_r[s-1];
      res_in[s] = res_r[s-1];
    end
  end

  // one digit of the root per stage; trial bit walks down by two
  always_comb begin
    logic [RW-1:0] bit_v;
    logic [RW-1:0] trial;
    for (int s = 0; s < STEPS; s++) begin
      bit_v = RW'(1) << (RW - 2 - 2 * s);
      trial = res_in[s] + bit_v;
      if (rem_in[s] >= trial) begin
        rem_nxt[s] = rem_in[s] - trial;
        res_nxt[s] = (res_in[s] >> 1) + bit_v;
      end else begin
        rem_nxt[s] = rem_in[s];
        res_nxt[s] = res_in[s] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STEPS; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int s = 1; s < STEPS; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int s = 1; s < STEPS; s++) side_r[s] <= side_r[s-1];
      for (int s = 0; s < STEPS; s++) begin
        rem_r[s] <= rem_nxt[s];
        res_r[s] <= res_nxt[s];
      end
    end
  end

  assign vld_o  = vld_r[STEPS-1];
  assign root_o = res_r[STEPS-1][tfn_pkg::ROOT_W-1:0];
  assign side_o = side_r[STEPS-1];

endmodule

[rtl/core/tfn_div.sv]
// Three-lane pipelined restoring divider sharing one divisor,
// one quotient bit per stage.
module tfn_div #(
  parameter int SW = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_i,
  input  logic [2:0][tfn_pkg::NUM_W-1:0]      num_i,
  input  logic [tfn_pkg::ROOT_W-1:0]          den_i,
  input  logic [SW-1:0]                       side_i,
  output logic                                vld_o,
  output logic [2:0][tfn_pkg::QUO_W-1:0]      quo_o,
  output logic [SW-1:0]                       side_o
);

  localparam int STEPS = tfn_pkg::QUO_W;
  localparam int DW    = tfn_pkg::ROOT_W;
  localparam int NW    = tfn_pkg::NUM_W;

  logic [2:0][DW-1:0]    rem_r   [STEPS];
  logic [2:0][NW-1:0]    num_r   [STEPS];
  logic [2:0][STEPS-1:0] quo_r   [STEPS];
  logic [DW-1:0]         den_r   [STEPS];
  logic [SW-1:0]         side_r  [STEPS];
  logic                  vld_r   [STEPS];
  logic [2:0][DW-1:0]    rem_in  [STEPS];
  logic [2:0][NW-1:0]    num_in  [STEPS];
  logic [2:0][STEPS-1:0] quo_in  [STEPS];
  logic [DW-1:0]         den_in  [STEPS];
  logic [2:0][DW-1:0]    rem_nxt [STEPS];
  logic [2:0][STEPS-1:0] quo_nxt [STEPS];

  // partial remainder starts at the dividend bits above the quotient
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_in[0][k] = DW'(num_i[k][NW-1:STEPS]);
      num_in[0][k] = num_i[k];
      quo_in[0][k] = '0;
    end
    den_in[0] = den_i;
    for (int s = 1; s < STEPS; s++) begin
      rem_in[s] = rem_r[s-1];
      num_in[s] = num_r[s-1];
      quo_in[s] = quo_r[s-1];
      den_in[s] = den_r[s-1];
    end
  end

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    logic [DW:0] trial;
    for (int s = 0; s < STEPS; s++) begin
      for (int k = 0; k < 3; k++) begin
        trial = {rem_in[s][k], num_in[s][k][STEPS-1-s]};
        if (trial >= {1'b0, den_in[s]}) begin
          rem_nxt[s][k] = DW'(trial - {1'b0, den_in[s]});
          quo_nxt[s][k] = {quo_in[s][k][STEPS-2:0], 1'b1};
        end else begin
          rem_nxt[s][k] = DW'(trial);
          quo_nxt[s][k] = {quo_in[s][k][STEPS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STEPS; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int s = 1; s < STEPS; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int s = 1; s < STEPS; s++) side_r[s] <= side_r[s-1];
      for (int s = 0; s < STEPS; s++) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
        num_r[s] <= num_in[s];
        den_r[s] <= den_in[s];
      end
    end
  end

  assign vld_o  = vld_r[STEPS-1];
  assign quo_o  = quo_r[STEPS-1];
  assign side_o = side_r[STEPS-1];

endmodule

[rtl/core/tfn_norm.sv]
// Vector normalizer: sign/magnitude split, left-align to 31 bits,
// sum of squares, square root, three divides, sign restore.
module tfn_norm #(
  parameter int W  = 33,
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  logic [2:0][W-1:0]     vec_i,    // signed components
  input  logic [SW-1:0]         side_i,
  output logic                  vld_o,
  output tfn_pkg::uvec_t        u_o,
  output logic                  zero_o,
  output logic [SW-1:0]         side_o
);

  localparam int LZW = $clog2(W + 1);
  localparam int MW  = tfn_pkg::MAG_W;
  localparam int FW  = tfn_pkg::FRAC_W;
  localparam int NW  = tfn_pkg::NUM_W;
  localparam int SQW = 2 * MW;
  localparam int QW  = tfn_pkg::QUO_W;
  localparam int UW  = tfn_pkg::UNIT_W;
  localparam int RW  = tfn_pkg::ROOT_W;
  localparam int ISW = 3 * MW + 3 + 1 + SW;   // carried around the root
  localparam int DSW = 3 + 1 + SW;            // carried around the divide

  // stage valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  // stage 1: sign and magnitude
  logic [2:0]         neg1_r;
  logic [2:0][W-1:0]  mag1_r;
  logic [SW-1:0]      side1_r;
  // stage 2: leading zeros of the largest magnitude
  logic [2:0]         neg2_r;
  logic [2:0][W-1:0]  mag2_r;
  logic [LZW-1:0]     lz2_r;
  logic               zero2_r;
  logic [SW-1:0]      side2_r;
  // stage 3: left-aligned magnitudes
  logic [2:0]         neg3_r;
  logic [2:0][MW-1:0] mn3_r;
  logic               zero3_r;
  logic [SW-1:0]      side3_r;
  // stage 4: squares
  logic [2:0]         neg4_r;
  logic [2:0][MW-1:0] mn4_r;
  logic [2:0][SQW-1:0] sq4_r;
  logic               zero4_r;
  logic [SW-1:0]      side4_r;
  // stage 5: sum of squares
  logic [2:0]         neg5_r;
  logic [2:0][MW-1:0] mn5_r;
  logic [tfn_pkg::RAD_W-1:0] sum5_r;
  logic               zero5_r;
  logic [SW-1:0]      side5_r;
  // stage 6: dividends
  logic [2:0]         neg6_r;
  logic [2:0][NW-1:0] num6_r;
  logic [RW-1:0]      den6_r;
  logic               zero6_r;
  logic [SW-1:0]      side6_r;
  // stage 7: signed unit vector
  tfn_pkg::uvec_t     u7_r;
  logic               zero7_r;
  logic [SW-1:0]      side7_r;

  logic [2:0][W-1:0]  mag1_nxt;
  logic [LZW-1:0]     lz2_nxt;
  logic [2:0][MW-1:0] mn3_nxt;

  logic               vs_q;
  logic [RW-1:0]      root_q;
  logic [ISW-1:0]     iside_q;
  logic [2:0][MW-1:0] mn_q;
  logic [2:0]         neg_q;
  logic               zero_q;
  logic [SW-1:0]      sside_q;

  logic               vd_q;
  logic [2:0][QW-1:0] quo_q;
  logic [DSW-1:0]     dside_q;
  logic [2:0]         dneg_q;
  logic               dzero_q;
  logic [SW-1:0]      dsd_q;

  // magnitudes of the signed components
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag1_nxt[k] = vec_i[k][W-1] ? W'(-vec_i[k]) : vec_i[k];
    end
  end

  // bit length of the largest magnitude equals that of the OR of all three
  always_comb begin
    logic [W-1:0] any_v;
    any_v   = mag1_r[0] | mag1_r[1] | mag1_r[2];
    lz2_nxt = LZW'(W);
    for (int i = 0; i < W; i++) begin
      if (any_v[i]) lz2_nxt = LZW'(W - 1 - i);
    end
  end

  // left-align and keep the top 31 bits (truncates when longer)
  always_comb begin
    logic [W-1:0] sh_v;
    for (int k = 0; k < 3; k++) begin
      sh_v       = mag2_r[k] << lz2_r;
      mn3_nxt[k] = sh_v[W-1 -: MW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= vs_q;
      v7_r <= vd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) neg1_r[k] <= vec_i[k][W-1];
      mag1_r  <= mag1_nxt;
      side1_r <= side_i;

      neg2_r  <= neg1_r;
      mag2_r  <= mag1_r;
      lz2_r   <= lz2_nxt;
      zero2_r <= ((mag1_r[0] | mag1_r[1] | mag1_r[2]) == '0);
      side2_r <= side1_r;

      neg3_r  <= neg2_r;
      mn3_r   <= mn3_nxt;
      zero3_r <= zero2_r;
      side3_r <= side2_r;

      neg4_r  <= neg3_r;
      mn4_r   <= mn3_r;
      for (int k = 0; k < 3; k++) sq4_r[k] <= SQW'(mn3_r[k]) * SQW'(mn3_r[k]);
      zero4_r <= zero3_r;
      side4_r <= side3_r;

      neg5_r  <= neg4_r;
      mn5_r   <= mn4_r;
      sum5_r  <= 64'(sq4_r[0]) + 64'(sq4_r[1]) + 64'(sq4_r[2]);
      zero5_r <= zero4_r;
      side5_r <= side4_r;

      // dividend mag*2^30 plus half the length, rounding half up
      neg6_r  <= neg_q;
      for (int k = 0; k < 3; k++) begin
        num6_r[k] <= NW'({mn_q[k], {FW{1'b0}}}) + NW'(root_q[RW-1:1]);
      end
      den6_r  <= root_q;
      zero6_r <= zero_q;
      side6_r <= sside_q;

      // restore signs; zero vector gives zero
      for (int k = 0; k < 3; k++) begin
        if (dzero_q) u7_r[k] <= '0;
        else if (dneg_q[k]) u7_r[k] <= -UW'(quo_q[k]);
        else u7_r[k] <= UW'(quo_q[k]);
      end
      zero7_r <= dzero_q;
      side7_r <= dsd_q;
    end
  end

  tfn_isqrt #(.SW(ISW)) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v5_r),
    .rad_i  (sum5_r),
    .side_i ({mn5_r, neg5_r, zero5_r, side5_r}),
    .vld_o  (vs_q),
    .root_o (root_q),
    .side_o (iside_q)
  );

  assign {mn_q, neg_q, zero_q, sside_q} = iside_q;

  tfn_div #(.SW(DSW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v6_r),
    .num_i  (num6_r),
    .den_i  (den6_r),
    .side_i ({neg6_r, zero6_r, side6_r}),
    .vld_o  (vd_q),
    .quo_o  (quo_q),
    .side_o (dside_q)
  );

  assign {dneg_q, dzero_q, dsd_q} = dside_q;

  assign vld_o  = v7_r;
  assign u_o    = u7_r;
  assign zero_o = zero7_r;
  assign side_o = side7_r;

endmodule

[rtl/core/tfn_cross.sv]
// Corner dot products, corner choice and cross product of its unit edges.
// Edge units come in as u(B-A), u(C-A), u(C-B); the reversed edges are
// their negations.
module tfn_cross (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  vld_i,
  input  tfn_pkg::uvec_t                        uba_i,
  input  tfn_pkg::uvec_t                        uca_i,
  input  tfn_pkg::uvec_t                        ucb_i,
  input  logic                                  deg_i,
  output logic                                  vld_o,
  output logic [2:0][tfn_pkg::CROSS_W-1:0]      cr_o,
  output tfn_pkg::cross_side_t                  side_o
);

  localparam int PW = tfn_pkg::PROD_W;
  localparam int CW = tfn_pkg::CROSS_W;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // stage 1: per-corner component products
  tfn_pkg::uvec_t uba1_r, uca1_r, ucb1_r;
  logic [2:0][2:0][PW-1:0] pr1_r;     // [corner][component]
  logic deg1_r;
  // stage 2: absolute dot products
  tfn_pkg::uvec_t uba2_r, uca2_r, ucb2_r;
  logic [2:0][PW-1:0] dot2_r;
  logic deg2_r;
  // stage 3: chosen corner's edges
  tfn_pkg::uvec_t e1_3_r, e2_3_r;
  tfn_pkg::corner_t corner3_r;
  logic deg3_r;
  // stage 4: cross terms
  logic [5:0][PW-1:0] m4_r;
  tfn_pkg::cross_side_t side4_r;
  // stage 5: cross product
  logic [2:0][CW-1:0] cr5_r;
  tfn_pkg::cross_side_t side5_r;

  logic [2:0][PW-1:0] dot2_nxt;
  tfn_pkg::corner_t   corner3_nxt;
  tfn_pkg::uvec_t     e1_3_nxt, e2_3_nxt;

  // |sum| of the three products per corner
  always_comb begin
    logic signed [PW-1:0] s_v;
    for (int c = 0; c < 3; c++) begin
      s_v = $signed(pr1_r[c][0]) + $signed(pr1_r[c][1]) + $signed(pr1_r[c][2]);
      dot2_nxt[c] = s_v[PW-1] ? PW'(-s_v) : PW'(s_v);
    end
  end

  // smallest |dot| wins, earlier corner on ties; degenerate edges pin A
  always_comb begin
    logic [PW-1:0] best_v;
    corner3_nxt = tfn_pkg::CORNER_A;
    best_v      = dot2_r[0];
    if (dot2_r[1] < best_v) begin
      corner3_nxt = tfn_pkg::CORNER_B;
      best_v      = dot2_r[1];
    end
    if (dot2_r[2] < best_v) corner3_nxt = tfn_pkg::CORNER_C;
    if (deg2_r) corner3_nxt = tfn_pkg::CORNER_A;
  end

  // edge pairs: A (B-A, C-A), B (C-B, A-B), C (A-C, B-C)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (corner3_nxt)
        tfn_pkg::CORNER_B: begin
          e1_3_nxt[k] = ucb2_r[k];
          e2_3_nxt[k] = -uba2_r[k];
        end
        tfn_pkg::CORNER_C: begin
          e1_3_nxt[k] = -uca2_r[k];
          e2_3_nxt[k] = -ucb2_r[k];
        end
        default: begin
          e1_3_nxt[k] = uba2_r[k];
          e2_3_nxt[k] = uca2_r[k];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uba1_r <= uba_i;
      uca1_r <= uca_i;
      ucb1_r <= ucb_i;
      deg1_r <= deg_i;
      // sign of corner B's dot vanishes in the absolute value
      for (int k = 0; k < 3; k++) begin
        pr1_r[0][k] <= PW'($signed(uba_i[k]) * $signed(uca_i[k]));
        pr1_r[1][k] <= PW'($signed(ucb_i[k]) * $signed(uba_i[k]));
        pr1_r[2][k] <= PW'($signed(uca_i[k]) * $signed(ucb_i[k]));
      end

      uba2_r <= uba1_r;
      uca2_r <= uca1_r;
      ucb2_r <= ucb1_r;
      dot2_r <= dot2_nxt;
      deg2_r <= deg1_r;

      e1_3_r    <= e1_3_nxt;
      e2_3_r    <= e2_3_nxt;
      corner3_r <= corner3_nxt;
      deg3_r    <= deg2_r;

      m4_r[0] <= PW'($signed(e1_3_r[1]) * $signed(e2_3_r[2]));
      m4_r[1] <= PW'($signed(e1_3_r[2]) * $signed(e2_3_r[1]));
      m4_r[2] <= PW'($signed(e1_3_r[2]) * $signed(e2_3_r[0]));
      m4_r[3] <= PW'($signed(e1_3_r[0]) * $signed(e2_3_r[2]));
      m4_r[4] <= PW'($signed(e1_3_r[0]) * $signed(e2_3_r[1]));
      m4_r[5] <= PW'($signed(e1_3_r[1]) * $signed(e2_3_r[0]));
      side4_r.corner   <= corner3_r;
      side4_r.edge_deg <= deg3_r;

      cr5_r[0] <= CW'(m4_r[0] - m4_r[1]);
      cr5_r[1] <= CW'(m4_r[2] - m4_r[3]);
      cr5_r[2] <= CW'(m4_r[4] - m4_r[5]);
      side5_r  <= side4_r;
    end
  end

  assign vld_o  = v5_r;
  assign cr_o   = cr5_r;
  assign side_o = side5_r;

endmodule

[rtl/core/triangle_face_normal_top.sv]
// Triangle unit face normal. Takes one triangle per cycle (three Q16.16
// vertices) and returns its unit normal in Q2.30 together with the corner
// whose edges were used and a degenerate flag. Its stages, in order, are
// one edge stage, a 70-stage edge normalizer, a 5-stage corner select and
// cross product, a second 70-stage normalizer and the output register.
// Each normalizer is dominated by its 32-stage square root and 31-stage
// divider, each retiring one bit per stage. Throughput is one item per
// cycle; the whole pipeline holds while a result waits on out_tready.
// Coincident vertices give degenerate = 1, corner A and a zero normal;
// collinear vertices give degenerate = 1 and a zero normal.
module triangle_face_normal_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // ax, ay, az, bx, by, bz, cx, cy, cz
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // nx, ny, nz, best_corner, zero pad
  output logic         out_tuser   // degenerate
);

  localparam int CDW = tfn_pkg::COORD_W;
  localparam int EW  = tfn_pkg::EDGE_W;
  localparam int SDW = $bits(tfn_pkg::cross_side_t);

  logic en;

  // edge stage
  logic               e_v_r;
  logic [2:0][EW-1:0] eba_r, eca_r, ecb_r;

  logic               nv_q [3];
  tfn_pkg::uvec_t     u_q  [3];
  logic               z_q  [3];

  logic                                  cv_q;
  logic [2:0][tfn_pkg::CROSS_W-1:0]      cr_q;
  tfn_pkg::cross_side_t                  cside_q;

  logic                 fv_q;
  tfn_pkg::uvec_t       fu_q;
  logic                 fz_q;
  logic [SDW-1:0]       fside_raw_q;
  tfn_pkg::cross_side_t fside_q;

  // output register
  logic               out_valid_r;
  tfn_pkg::uvec_t     n_r;
  tfn_pkg::corner_t   corner_r;
  logic               deg_r;

  // pipeline advances unless a result is held
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // exact edge differences
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [EW-1:0] a_v, b_v, c_v;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_v = EW'($signed(in_tdata[k*CDW +: CDW]));
        b_v = EW'($signed(in_tdata[(3+k)*CDW +: CDW]));
        c_v = EW'($signed(in_tdata[(6+k)*CDW +: CDW]));
        eba_r[k] <= b_v - a_v;
        eca_r[k] <= c_v - a_v;
        ecb_r[k] <= c_v - b_v;
      end
    end
  end

  // unit edges B-A, C-A, C-B
  tfn_norm #(.W(EW), .SW(1)) u_norm_ba (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(e_v_r), .vec_i(eba_r),
    .side_i(1'b0), .vld_o(nv_q[0]), .u_o(u_q[0]), .zero_o(z_q[0]), .side_o()
  );
  tfn_norm #(.W(EW), .SW(1)) u_norm_ca (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(e_v_r), .vec_i(eca_r),
    .side_i(1'b0), .vld_o(nv_q[1]), .u_o(u_q[1]), .zero_o(z_q[1]), .side_o()
  );
  tfn_norm #(.W(EW), .SW(1)) u_norm_cb (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(e_v_r), .vec_i(ecb_r),
    .side_i(1'b0), .vld_o(nv_q[2]), .u_o(u_q[2]), .zero_o(z_q[2]), .side_o()
  );

  tfn_cross u_cross (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (nv_q[0] & nv_q[1] & nv_q[2]),
    .uba_i  (u_q[0]),
    .uca_i  (u_q[1]),
    .ucb_i  (u_q[2]),
    .deg_i  (z_q[0] | z_q[1] | z_q[2]),
    .vld_o  (cv_q),
    .cr_o   (cr_q),
    .side_o (cside_q)
  );

  // unit normal
  tfn_norm #(.W(tfn_pkg::CROSS_W), .SW(SDW)) u_norm_n (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(cv_q), .vec_i(cr_q),
    .side_i(cside_q), .vld_o(fv_q), .u_o(fu_q), .zero_o(fz_q),
    .side_o(fside_raw_q)
  );

  assign fside_q = tfn_pkg::cross_side_t'(fside_raw_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fv_q;
    end
  end

  // degenerate edges blank the normal computed from garbage edges
  always_ff @(posedge clk) begin
    if (en) begin
      n_r      <= fside_q.edge_deg ? '0 : fu_q;
      corner_r <= fside_q.corner;
      deg_r    <= fside_q.edge_deg | fz_q;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, corner_r, n_r[2], n_r[1], n_r[0]};
  assign out_tuser  = deg_r;

  // degenerate results carry a zero normal
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[95:0] == '0)
    else $error("degenerate item with nonzero normal");

  // a good result is never the zero vector
  a_good_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[95:0] != '0)
    else $error("nondegenerate item with zero normal");

  // corner code stays within A, B, C
  a_corner_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[97:96] != 2'd3)
    else $error("corner code out of range");

  // held result stalls the input
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result held");

endmodule
